@@ rtl/cps_pkg.sv @@
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants of the closest polyline search block.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned Verts     = 1024;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ShapeW    = 8;
  localparam int unsigned DsqW      = 50;
  localparam int unsigned DresW     = 25;

  localparam int unsigned AddrW = $clog2(Verts);
  localparam int unsigned CntW  = $clog2(Verts + 1);
  localparam int unsigned DiffW = CoordBits + 2;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned AccW  = ProdW + 1;

  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdBreak  = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [ShapeW-1:0]           shape_id;
    logic signed [CoordBits-1:0] x_coord;
    logic signed [CoordBits-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ShapeW-1:0] shape_index;
    logic [DsqW-1:0]   dist_sq;
    logic [DresW-1:0]  dist_res;
    logic              overflow;
  } res_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] vx;
    logic signed [CoordBits-1:0] vy;
    logic signed [CoordBits-1:0] wx;
    logic signed [CoordBits-1:0] wy;
  } seg_req_t;

endpackage

@@ rtl/cps_seg_unit.sv @@
// ----------------------------------------------------------------------------
// cps_seg_unit
// Squared distance from a point to a segment, computed with one shared
// multiplier and a restoring divider for the projection fraction.
// ----------------------------------------------------------------------------
module cps_seg_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  cps_pkg::seg_req_t             req_i,
  output logic                          done_o,
  output logic [cps_pkg::ProdW-1:0]     dist_o
);

  localparam int unsigned DiffW = cps_pkg::DiffW;
  localparam int unsigned ProdW = cps_pkg::ProdW;
  localparam int unsigned AccW  = cps_pkg::AccW;
  localparam int unsigned FracBits = cps_pkg::FracBits;
  localparam int unsigned FcW   = $clog2(FracBits);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SL2X  = 4'd1;
  localparam logic [3:0] SL2Y  = 4'd2;
  localparam logic [3:0] SL2S  = 4'd3;
  localparam logic [3:0] SDtX  = 4'd4;
  localparam logic [3:0] SDtY  = 4'd5;
  localparam logic [3:0] SDtS  = 4'd6;
  localparam logic [3:0] SCls  = 4'd7;
  localparam logic [3:0] SDiv  = 4'd8;
  localparam logic [3:0] SOfX  = 4'd9;
  localparam logic [3:0] SOfY  = 4'd10;
  localparam logic [3:0] SQY   = 4'd11;
  localparam logic [3:0] SDsX  = 4'd12;
  localparam logic [3:0] SDsY  = 4'd13;
  localparam logic [3:0] SDsS  = 4'd14;

  logic [3:0]              state_q, state_d;
  cps_pkg::seg_req_t       req_q, req_d;
  logic signed [DiffW-1:0] dx_q, dx_d, dy_q, dy_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [DiffW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d, dot_q, dot_d;
  logic [AccW-1:0]         l2_q, l2_d, rem_q, rem_d, rem2;
  logic [FracBits-1:0]     t_q, t_d;
  logic [FcW-1:0]          cnt_q, cnt_d;
  logic [ProdW-1:0]        dist_q, dist_d;
  logic                    done_q, done_d;

  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [DiffW-1:0] mag_dx, mag_dy, t_op, off, sx, sy;
  logic signed [AccW-1:0]  prod_ext, acc_sum;

  assign mag_dx   = dx_q[DiffW-1] ? -dx_q : dx_q;
  assign mag_dy   = dy_q[DiffW-1] ? -dy_q : dy_q;
  assign t_op     = $signed({{(DiffW - FracBits){1'b0}}, t_q});
  assign off      = DiffW'(prod_q >>> FracBits);
  assign sx       = DiffW'(req_q.px) - qx_q;
  assign sy       = DiffW'(req_q.py) - qy_q;
  assign prod_ext = AccW'(prod_q);
  assign acc_sum  = acc_q + prod_ext;
  assign rem2     = {rem_q[AccW-2:0], 1'b0};
  assign prod_d   = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    acc_d   = acc_q;
    dot_d   = dot_q;
    l2_d    = l2_q;
    rem_d   = rem_q;
    t_d     = t_q;
    cnt_d   = cnt_q;
    dist_d  = dist_q;
    done_d  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          req_d   = req_i;
          dx_d    = DiffW'(req_i.wx) - DiffW'(req_i.vx);
          dy_d    = DiffW'(req_i.wy) - DiffW'(req_i.vy);
          ex_d    = DiffW'(req_i.px) - DiffW'(req_i.vx);
          ey_d    = DiffW'(req_i.py) - DiffW'(req_i.vy);
          state_d = SL2X;
        end
      end
      SL2X: begin
        mul_a = dx_q;
        mul_b = dx_q;
        state_d = SL2Y;
      end
      SL2Y: begin
        mul_a = dy_q;
        mul_b = dy_q;
        acc_d = prod_ext;
        state_d = SL2S;
      end
      SL2S: begin
        l2_d = $unsigned(acc_sum);
        state_d = SDtX;
      end
      SDtX: begin
        mul_a = ex_q;
        mul_b = dx_q;
        state_d = SDtY;
      end
      SDtY: begin
        mul_a = ey_q;
        mul_b = dy_q;
        acc_d = prod_ext;
        state_d = SDtS;
      end
      SDtS: begin
        dot_d = acc_sum;
        state_d = SCls;
      end
      SCls: begin
        if (l2_q == '0 || dot_q <= 0) begin
          qx_d = DiffW'(req_q.vx);
          qy_d = DiffW'(req_q.vy);
          state_d = SDsX;
        end else if ($unsigned(dot_q) >= l2_q) begin
          qx_d = DiffW'(req_q.wx);
          qy_d = DiffW'(req_q.wy);
          state_d = SDsX;
        end else begin
          rem_d = $unsigned(dot_q);
          t_d   = '0;
          cnt_d = '0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (rem2 >= l2_q) begin
          rem_d = rem2 - l2_q;
          t_d   = {t_q[FracBits-2:0], 1'b1};
        end else begin
          rem_d = rem2;
          t_d   = {t_q[FracBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FcW'(FracBits - 1)) begin
          state_d = SOfX;
        end
      end
      SOfX: begin
        mul_a = t_op;
        mul_b = mag_dx;
        state_d = SOfY;
      end
      SOfY: begin
        mul_a = t_op;
        mul_b = mag_dy;
        qx_d = dx_q[DiffW-1] ? DiffW'(req_q.vx) - off : DiffW'(req_q.vx) + off;
        state_d = SQY;
      end
      SQY: begin
        qy_d = dy_q[DiffW-1] ? DiffW'(req_q.vy) - off : DiffW'(req_q.vy) + off;
        state_d = SDsX;
      end
      SDsX: begin
        mul_a = sx;
        mul_b = sx;
        state_d = SDsY;
      end
      SDsY: begin
        mul_a = sy;
        mul_b = sy;
        acc_d = prod_ext;
        state_d = SDsS;
      end
      SDsS: begin
        dist_d  = ProdW'($unsigned(acc_sum));
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dot_q  <= dot_d;
    l2_q   <= l2_d;
    rem_q  <= rem_d;
    t_q    <= t_d;
    cnt_q  <= cnt_d;
    dist_q <= dist_d;
  end

  assign done_o = done_q;
  assign dist_o = dist_q;

endmodule

@@ rtl/closest_polyline_search.sv @@
// ----------------------------------------------------------------------------
// closest_polyline_search
// Vertex table of closed polyline rings with a nearest segment query.
// ----------------------------------------------------------------------------
// Append, part break and clear transactions do not raise busy_o. A query
// walks every stored segment through one shared segment distance unit,
// taking longer per segment when the projection divider runs than when the
// projection clamps, then takes a bit-serial square root; busy_o stays
// high for the whole query. The result appears on result_o for exactly one
// cycle with result_valid_o and cannot be held off, so it must be captured.
// ----------------------------------------------------------------------------
module closest_polyline_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cps_pkg::in_item_t    item_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  output cps_pkg::res_item_t   result_o
);

  localparam int unsigned CoordBits = cps_pkg::CoordBits;
  localparam int unsigned ShapeW = cps_pkg::ShapeW;
  localparam int unsigned AddrW  = cps_pkg::AddrW;
  localparam int unsigned CntW   = cps_pkg::CntW;
  localparam int unsigned ProdW  = cps_pkg::ProdW;
  localparam int unsigned DsqW   = cps_pkg::DsqW;
  localparam int unsigned DresW  = cps_pkg::DresW;
  localparam int unsigned SqcW   = $clog2(DresW);
  localparam int unsigned RemW   = DresW + 3;

  localparam logic [2:0] TIdle  = 3'd0;
  localparam logic [2:0] TRd    = 3'd1;
  localparam logic [2:0] TGot   = 3'd2;
  localparam logic [2:0] TWait  = 3'd3;
  localparam logic [2:0] TCls   = 3'd4;
  localparam logic [2:0] TCWait = 3'd5;
  localparam logic [2:0] TSq    = 3'd6;
  localparam logic [2:0] TOut   = 3'd7;

  typedef struct packed {
    logic                        ps;
    logic [ShapeW-1:0]           sh;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } vert_t;

  vert_t vert_mem [cps_pkg::Verts];
  vert_t rd_q, wr_vert;
  logic  wr_en;

  logic [2:0]                  state_q, state_d;
  logic [CntW-1:0]             count_q, count_d, k_q, k_d;
  logic                        brk_q, brk_d, ovf_q, ovf_d;
  logic [ShapeW-1:0]           last_sh_q, last_sh_d;
  logic signed [CoordBits-1:0] px_q, px_d, py_q, py_d;
  vert_t                       cur_q, cur_d, first_q, first_d, new_q, new_d;
  logic [ProdW-1:0]            best_q, best_d;
  logic [ShapeW-1:0]           bsh_q, bsh_d;
  logic                        bvld_q, bvld_d;
  logic [DsqW-1:0]             dsq_q, dsq_d, sqv_q, sqv_d;
  logic [RemW-1:0]             srem_q, srem_d, srem_n, trial;
  logic [DresW-1:0]            root_q, root_d;
  logic [SqcW-1:0]             sqc_q, sqc_d;
  logic                        found_q, found_d;
  logic                        vld_q, vld_d;
  cps_pkg::res_item_t          res_q, res_d;

  logic                        seg_start, seg_done;
  cps_pkg::seg_req_t           seg_req;
  logic [ProdW-1:0]            seg_dist;
  logic                        accept;
  logic [ProdW-1:0]            upd_best;
  logic [ShapeW-1:0]           upd_sh;
  logic [DsqW-1:0]             sat_dsq;

  cps_seg_unit u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_start),
    .req_i   (seg_req),
    .done_o  (seg_done),
    .dist_o  (seg_dist)
  );

  assign accept = start_i && (state_q == TIdle);

  assign upd_best = (!bvld_q || seg_dist < best_q) ? seg_dist : best_q;
  assign upd_sh   = (!bvld_q || seg_dist < best_q) ? cur_q.sh : bsh_q;
  assign sat_dsq  = (upd_best > ProdW'({DsqW{1'b1}})) ? {DsqW{1'b1}} : DsqW'(upd_best);

  assign srem_n = {srem_q[RemW-3:0], sqv_q[DsqW-1:DsqW-2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    brk_d     = brk_q;
    ovf_d     = ovf_q;
    last_sh_d = last_sh_q;
    px_d      = px_q;
    py_d      = py_q;
    cur_d     = cur_q;
    first_d   = first_q;
    new_d     = new_q;
    best_d    = best_q;
    bsh_d     = bsh_q;
    bvld_d    = bvld_q;
    dsq_d     = dsq_q;
    sqv_d     = sqv_q;
    srem_d    = srem_q;
    root_d    = root_q;
    sqc_d     = sqc_q;
    found_d   = found_q;
    res_d     = res_q;
    vld_d     = 1'b0;
    wr_en     = 1'b0;
    wr_vert.ps = (count_q == '0) || brk_q || (last_sh_q != item_i.shape_id);
    wr_vert.sh = item_i.shape_id;
    wr_vert.x  = item_i.x_coord;
    wr_vert.y  = item_i.y_coord;
    seg_start  = 1'b0;
    seg_req.px = px_q;
    seg_req.py = py_q;
    seg_req.vx = cur_q.x;
    seg_req.vy = cur_q.y;
    seg_req.wx = first_q.x;
    seg_req.wy = first_q.y;
    case (state_q)
      TIdle: begin
        if (accept) begin
          case (item_i.cmd)
            cps_pkg::CmdAppend: begin
              if (count_q >= CntW'(cps_pkg::Verts)) begin
                ovf_d = 1'b1;
              end else begin
                wr_en     = 1'b1;
                brk_d     = 1'b0;
                last_sh_d = item_i.shape_id;
                count_d   = count_q + 1'b1;
              end
            end
            cps_pkg::CmdBreak: begin
              brk_d = 1'b1;
            end
            cps_pkg::CmdClear: begin
              count_d = '0;
              brk_d   = 1'b0;
              ovf_d   = 1'b0;
            end
            default: begin
              px_d    = item_i.x_coord;
              py_d    = item_i.y_coord;
              k_d     = '0;
              bvld_d  = 1'b0;
              found_d = (count_q != '0);
              if (count_q == '0) begin
                bsh_d   = '0;
                dsq_d   = '0;
                root_d  = '0;
                state_d = TOut;
              end else begin
                state_d = TRd;
              end
            end
          endcase
        end
      end
      TRd: begin
        state_d = TGot;
      end
      TGot: begin
        new_d = rd_q;
        if (k_q == '0) begin
          cur_d   = rd_q;
          first_d = rd_q;
          if (count_q == CntW'(1)) begin
            state_d = TCls;
          end else begin
            k_d     = CntW'(1);
            state_d = TRd;
          end
        end else begin
          seg_start = 1'b1;
          if (!rd_q.ps) begin
            seg_req.wx = rd_q.x;
            seg_req.wy = rd_q.y;
          end
          state_d = TWait;
        end
      end
      TWait: begin
        if (seg_done) begin
          best_d = upd_best;
          bsh_d  = upd_sh;
          bvld_d = 1'b1;
          cur_d  = new_q;
          if (new_q.ps) begin
            first_d = new_q;
          end
          if (k_q == count_q - 1'b1) begin
            state_d = TCls;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = TRd;
          end
        end
      end
      TCls: begin
        seg_start = 1'b1;
        state_d   = TCWait;
      end
      TCWait: begin
        if (seg_done) begin
          bsh_d   = upd_sh;
          dsq_d   = sat_dsq;
          sqv_d   = sat_dsq;
          srem_d  = '0;
          root_d  = '0;
          sqc_d   = '0;
          state_d = TSq;
        end
      end
      TSq: begin
        sqv_d = {sqv_q[DsqW-3:0], 2'b00};
        if (srem_n >= trial) begin
          srem_d = srem_n - trial;
          root_d = {root_q[DresW-2:0], 1'b1};
        end else begin
          srem_d = srem_n;
          root_d = {root_q[DresW-2:0], 1'b0};
        end
        sqc_d = sqc_q + 1'b1;
        if (sqc_q == SqcW'(DresW - 1)) begin
          state_d = TOut;
        end
      end
      TOut: begin
        res_d.found       = found_q;
        res_d.shape_index = bsh_q;
        res_d.dist_sq     = dsq_q;
        res_d.dist_res    = root_q;
        res_d.overflow    = ovf_q;
        vld_d             = 1'b1;
        state_d           = TIdle;
      end
      default: begin
        state_d = TIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TIdle;
      count_q   <= '0;
      brk_q     <= 1'b0;
      ovf_q     <= 1'b0;
      vld_q     <= 1'b0;
      bvld_q    <= 1'b0;
      k_q       <= '0;
      sqc_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      brk_q     <= brk_d;
      ovf_q     <= ovf_d;
      vld_q     <= vld_d;
      bvld_q    <= bvld_d;
      k_q       <= k_d;
      sqc_q     <= sqc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_sh_q <= last_sh_d;
    px_q      <= px_d;
    py_q      <= py_d;
    cur_q     <= cur_d;
    first_q   <= first_d;
    new_q     <= new_d;
    best_q    <= best_d;
    bsh_q     <= bsh_d;
    dsq_q     <= dsq_d;
    sqv_q     <= sqv_d;
    srem_q    <= srem_d;
    root_q    <= root_d;
    found_q   <= found_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vert_mem[count_q[AddrW-1:0]] <= wr_vert;
    end
    rd_q <= vert_mem[k_q[AddrW-1:0]];
  end

  assign busy_o         = (state_q != TIdle);
  assign result_valid_o = vld_q;
  assign result_o       = res_q;

endmodule

@@ test/cps_checker.sv @@
// ----------------------------------------------------------------------------
// cps_checker
// Watches the command and result channels of closest_polyline_search. It keeps
// its own copy of the vertex table, computes the expected query result for
// every accepted query transaction and compares each result field by field.
// ----------------------------------------------------------------------------
module cps_checker
  import cps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  input  logic      busy_i,
  input  logic      result_valid_i,
  input  res_item_t result_i,
  output int        fail_cnt_o,
  output int        pending_cnt_o
);

  localparam longint unsigned DsqMax  = (64'd1 << DsqW) - 1;
  localparam longint unsigned DresMax = (64'd1 << DresW) - 1;

  longint     tab_x     [Verts];
  longint     tab_y     [Verts];
  logic [7:0] tab_shape [Verts];
  bit         tab_start [Verts];
  int         tab_cnt;
  bit         brk_pend;
  bit         ovf_flag;
  res_item_t  nearest_q [$];

  assign pending_cnt_o = nearest_q.size();

  function automatic longint unsigned point_dsq(longint ax, longint ay, longint bx, longint by);
    longint sx, sy;
    sx = ax - bx;
    sy = ay - by;
    return longint'(sx * sx + sy * sy);
  endfunction

  function automatic longint unsigned seg_dsq(longint px, longint py, longint vx, longint vy,
                                              longint wx, longint wy);
    longint dx, dy, l2, dot, qx, qy;
    logic [127:0] num;
    longint unsigned t, ox, oy;
    dx = wx - vx;
    dy = wy - vy;
    l2 = dx * dx + dy * dy;
    if (l2 == 0) return point_dsq(px, py, vx, vy);
    dot = (px - vx) * dx + (py - vy) * dy;
    if (dot <= 0) return point_dsq(px, py, vx, vy);
    if (dot >= l2) return point_dsq(px, py, wx, wy);
    num = 128'(dot) << FracBits;
    t = 64'(num / 128'(l2));
    ox = (t * longint'(dx < 0 ? -dx : dx)) >> FracBits;
    oy = (t * longint'(dy < 0 ? -dy : dy)) >> FracBits;
    qx = dx < 0 ? vx - longint'(ox) : vx + longint'(ox);
    qy = dy < 0 ? vy - longint'(oy) : vy + longint'(oy);
    return point_dsq(px, py, qx, qy);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic res_item_t nearest_ring(longint px, longint py);
    res_item_t res;
    longint unsigned best, d;
    logic [7:0] best_shape;
    int ls, nx;
    best = 0;
    best_shape = '0;
    ls = 0;
    for (int k = 0; k < tab_cnt; k++) begin
      if (tab_start[k]) ls = k;
      nx = (k + 1 < tab_cnt && !tab_start[k + 1]) ? k + 1 : ls;
      d = seg_dsq(px, py, tab_x[k], tab_y[k], tab_x[nx], tab_y[nx]);
      if (k == 0 || d < best) begin
        best = d;
        best_shape = tab_shape[k];
      end
    end
    res.found       = tab_cnt != 0;
    res.shape_index = best_shape;
    if (best > DsqMax) begin
      res.dist_sq  = DsqW'(DsqMax);
      res.dist_res = DresW'(DresMax);
    end else begin
      res.dist_sq  = DsqW'(best);
      res.dist_res = DresW'(floor_sqrt(best));
    end
    res.overflow = ovf_flag;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_item_t exp;
    if (!rst_ni) begin
      tab_cnt  = 0;
      brk_pend = 0;
      ovf_flag = 0;
      nearest_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (start_i && !busy_i) begin
        case (item_i.cmd)
          CmdAppend: begin
            if (tab_cnt >= Verts) begin
              ovf_flag = 1;
            end else begin
              tab_x[tab_cnt]     = longint'(item_i.x_coord);
              tab_y[tab_cnt]     = longint'(item_i.y_coord);
              tab_shape[tab_cnt] = item_i.shape_id;
              tab_start[tab_cnt] = tab_cnt == 0 || brk_pend ||
                                   tab_shape[tab_cnt - 1] != item_i.shape_id;
              brk_pend = 0;
              tab_cnt++;
            end
          end
          CmdBreak: brk_pend = 1;
          CmdClear: begin
            tab_cnt  = 0;
            brk_pend = 0;
            ovf_flag = 0;
          end
          default: begin
            nearest_q.push_back(nearest_ring(longint'(item_i.x_coord),
                                             longint'(item_i.y_coord)));
          end
        endcase
      end
      if (result_valid_i) begin
        if (nearest_q.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          fail_cnt_o++;
        end else begin
          exp = nearest_q.pop_front();
          if (result_i.found != exp.found)
            report_mismatch("found", result_i.found, exp.found);
          if (result_i.shape_index != exp.shape_index)
            report_mismatch("shape_index", result_i.shape_index, exp.shape_index);
          if (result_i.dist_sq != exp.dist_sq)
            report_mismatch("dist_sq", result_i.dist_sq, exp.dist_sq);
          if (result_i.dist_res != exp.dist_res)
            report_mismatch("dist_res", result_i.dist_res, exp.dist_res);
          if (result_i.overflow != exp.overflow)
            report_mismatch("overflow", result_i.overflow, exp.overflow);
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for closest_polyline_search: a directed set of rings and queries
// covering coordinate extremes, breaks, point parts and a full table, then
// random ring sets with queries, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import cps_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_item_t  item_i;
  logic      busy_o;
  logic      result_valid_o;
  res_item_t result_o;
  int        fail_cnt;
  int        pending_cnt;
  int        burst_left;
  int        sent;

  closest_polyline_search u_top (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .result_valid_o, .result_o
  );

  cps_checker u_chk (
    .clk_i, .rst_ni, .start_i, .item_i,
    .busy_i         (busy_o),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fail_cnt_o     (fail_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #2000000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send(logic [1:0] cmd, int shape, int x, int y);
    if (burst_left == 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end else begin
      @(negedge clk_i);
    end
    burst_left--;
    start_i          = 1'b1;
    item_i.cmd       = cmd;
    item_i.shape_id  = shape[7:0];
    item_i.x_coord   = x[CoordBits-1:0];
    item_i.y_coord   = y[CoordBits-1:0];
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0:       return $urandom_range(0, 127) - 64;
      1:       return $urandom_range(0, 65535) - 32768;
      default: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
    endcase
  endfunction

  initial begin
    int mode, nparts, nv, shape;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    burst_left = 0;
    sent       = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(CmdQuery, 0, 5, -5);
    send(CmdBreak, 0, 0, 0);
    send(CmdBreak, 0, 0, 0);
    send(CmdAppend, 3, -8388608, -8388608);
    send(CmdQuery, 0, 8388607, 8388607);
    send(CmdAppend, 3, 8388607, -8388608);
    send(CmdAppend, 3, 8388607, 8388607);
    send(CmdAppend, 255, 100, 100);
    send(CmdBreak, 0, 0, 0);
    send(CmdAppend, 255, 100, 100);
    send(CmdAppend, 255, 100, 100);
    send(CmdBreak, 0, 0, 0);
    send(CmdAppend, 0, -50, 20);
    send(CmdAppend, 0, 70, -33);
    send(CmdQuery, 0, -8388608, 8388607);
    send(CmdQuery, 0, 100, 100);
    send(CmdQuery, 0, 3, 1);
    send(CmdQuery, 0, 0, 0);
    send(CmdClear, 0, 0, 0);
    send(CmdQuery, 0, 1, 1);
    send(CmdAppend, 7, 0, 0);
    send(CmdQuery, 0, -8388608, -8388608);

    // Hold off until the table is quiet, then fill it past capacity.
    @(negedge clk_i);
    start_i    = 1'b0;
    burst_left = 0;
    wait (pending_cnt == 0);
    send(CmdClear, 0, 0, 0);
    for (int i = 0; i < Verts + 2; i++)
      send(CmdAppend, i / 200, rand_coord(2), rand_coord(2));
    send(CmdQuery, 0, rand_coord(2), rand_coord(2));
    send(CmdClear, 0, 0, 0);
    send(CmdQuery, 0, 0, 0);

    sent = 0;
    while (sent < 580) begin
      if ($urandom_range(0, 9) == 0) begin
        send(2'($urandom), $urandom_range(0, 255), rand_coord(2), rand_coord(2));
      end else begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 3) != 0) send(CmdClear, 0, 0, 0);
        nparts = $urandom_range(1, 4);
        shape  = $urandom_range(0, 255);
        for (int p = 0; p < nparts; p++) begin
          nv = $urandom_range(1, 6);
          if ($urandom_range(0, 1)) send(CmdBreak, 0, 0, 0);
          else if ($urandom_range(0, 1)) shape = $urandom_range(0, 255);
          for (int v = 0; v < nv; v++)
            send(CmdAppend, shape, rand_coord(mode), rand_coord(mode));
        end
        repeat ($urandom_range(1, 3))
          send(CmdQuery, 0, rand_coord(mode), rand_coord(mode));
      end
    end

    @(negedge clk_i);
    start_i = 1'b0;
    wait (pending_cnt == 0);
    repeat (64) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
